@@ sv/pemr_pkg.sv @@
`timescale 1ns / 1ps

package pemr_pkg;

	localparam int TAG_W   = 8;
	localparam int COORD_W = 16;
	localparam int BTN_W   = 5;
	localparam int STAMP_W = 32;

	// action codes
	localparam logic [1:0] ACT_READ    = 2'd0;
	localparam logic [1:0] ACT_POINTER = 2'd1;
	localparam logic [1:0] ACT_RESIZE  = 2'd2;

	// where the fields of a reply come from
	typedef enum logic [2:0] {
		KIND_ERR     = 3'b001,
		KIND_EV_MEM  = 3'b010,
		KIND_TAG_MEM = 3'b100
	} reply_kind_t;

	typedef struct packed {
		logic [STAMP_W-1:0]        stamp;
		logic [BTN_W-1:0]          buttons;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} event_t;

	localparam int EVENT_W = $bits(event_t);

endpackage

@@ sv/pemr_ram.sv @@
`timescale 1ns / 1ps

module pemr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/pointer_event_read_matcher_unit.sv @@
`timescale 1ns / 1ps
// Pipeline: an accepted item passes the first stage (control and ring reads) and then
// the result register.
// Throughput: one item per cycle while no stalled result blocks the pipeline; the
// registered read ports of the event and tag rings do not limit the rate.
// Reset: arst_n clears ring pointers, stall, resized mark, last pointer state and valids;
// ring contents are not cleared and need no clearing pass.

module pointer_event_read_matcher_unit
	import pemr_pkg::*;
#(
	parameter int RING_DEPTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [1:0]                action,
	input  logic [TAG_W-1:0]          req_tag,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [BTN_W-1:0]          button_bits,
	input  logic [STAMP_W-1:0]        stamp_ms,
	input  logic [BTN_W-1:0]          modifier_buttons,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic                      is_error,
	output logic [TAG_W-1:0]          reply_tag,
	output logic signed [COORD_W-1:0] out_x,
	output logic signed [COORD_W-1:0] out_y,
	output logic [BTN_W-1:0]          out_buttons,
	output logic [STAMP_W-1:0]        out_stamp,
	output logic                      was_resized
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(RING_DEPTH - 1);
	localparam logic [PTR_W-1:0] ONE_IDX  = PTR_W'(1);

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	// ring state
	logic [PTR_W-1:0] ev_rd_q, ev_wr_q, tag_rd_q, tag_wr_q;
	logic [PTR_W-1:0] ev_rd_d, ev_wr_d, tag_rd_d, tag_wr_d;
	logic             stalled_q, stalled_d;
	logic             resized_q, resized_d;
	event_t           last_ev_q, last_ev_d;

	// first stage
	logic             valid_s1, valid_d;
	reply_kind_t      kind_s1, kind_d;
	logic [TAG_W-1:0] tag_s1;
	event_t           ev_s1;
	logic             resized_s1, resized_out_d;

	// result register
	logic             result_valid_q;
	logic             is_error_q;
	logic [TAG_W-1:0] reply_tag_q;
	event_t           res_ev_q;
	logic             was_resized_q;

	logic             advance, s1_load, accept;
	logic             ev_empty, tag_empty, ev_full_hit;
	logic [PTR_W-1:0] ev_wr_bump, tag_wr_bump;
	event_t           port_ev, queued_ev;
	logic             ev_we, tag_we;
	logic [PTR_W-1:0] ev_waddr;
	event_t           ev_rd_data;
	logic [TAG_W-1:0] tag_rd_data;
	logic             res_err;
	logic [TAG_W-1:0] res_tag;
	event_t           res_ev;

	assign advance    = !result_valid_q || !result_stall;
	assign s1_load    = !valid_s1 || advance;
	assign item_stall = !s1_load;
	assign accept     = item_valid && s1_load;

	assign port_ev = '{stamp: stamp_ms, buttons: button_bits, y: pos_y, x: pos_x};

	always_comb begin
		ev_rd_d       = ev_rd_q;
		ev_wr_d       = ev_wr_q;
		tag_rd_d      = tag_rd_q;
		tag_wr_d      = tag_wr_q;
		stalled_d     = stalled_q;
		resized_d     = resized_q;
		last_ev_d     = last_ev_q;
		valid_d       = 1'b0;
		kind_d        = KIND_ERR;
		resized_out_d = 1'b0;
		ev_we         = 1'b0;
		tag_we        = 1'b0;
		ev_waddr      = ev_wr_q;

		ev_empty    = (ev_rd_q == ev_wr_q);
		tag_empty   = (tag_rd_q == tag_wr_q);
		ev_wr_bump  = bump(ev_wr_q);
		tag_wr_bump = bump(tag_wr_q);
		ev_full_hit = (ev_wr_bump == ev_rd_q);

		queued_ev         = (action == ACT_POINTER) ? port_ev : last_ev_q;
		queued_ev.buttons = queued_ev.buttons | modifier_buttons;

		if (accept) begin
			case (action)
				ACT_READ: begin
					if (tag_wr_bump == tag_rd_q) begin
						// tag ring full: drop the request, report it
						valid_d = 1'b1;
						kind_d  = KIND_ERR;
					end else begin
						tag_we    = 1'b1;
						tag_wr_d  = tag_wr_bump;
						stalled_d = 1'b0;
						if (!ev_empty) begin
							// tag ring was empty, so the oldest tag is this one
							valid_d       = 1'b1;
							kind_d        = KIND_EV_MEM;
							resized_out_d = resized_q;
							resized_d     = 1'b0;
							ev_rd_d       = bump(ev_rd_q);
							tag_rd_d      = bump(tag_rd_q);
						end
					end
				end
				ACT_POINTER, ACT_RESIZE: begin
					if (action == ACT_RESIZE || !stalled_q) begin
						if (action == ACT_POINTER) begin
							last_ev_d = port_ev;
						end
						if (action == ACT_RESIZE) begin
							resized_d = 1'b1;
						end
						ev_we = 1'b1;
						if (ev_full_hit) begin
							// collapse to the newest event alone
							stalled_d = 1'b1;
							ev_rd_d   = '0;
							ev_wr_d   = ONE_IDX;
							ev_waddr  = '0;
						end else begin
							ev_wr_d = ev_wr_bump;
						end
						if (!tag_empty) begin
							// event ring was empty, so the event delivered is this one
							valid_d       = 1'b1;
							kind_d        = KIND_TAG_MEM;
							resized_out_d = resized_d;
							resized_d     = 1'b0;
							ev_rd_d       = bump(ev_rd_d);
							tag_rd_d      = bump(tag_rd_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	pemr_ram #(
		.WIDTH (EVENT_W),
		.DEPTH (RING_DEPTH)
	) u_pemr_ev_ram (
		.clk     (clk),
		.wr_en   (ev_we),
		.wr_addr (ev_waddr),
		.wr_data (queued_ev),
		.rd_en   (s1_load),
		.rd_addr (ev_rd_q),
		.rd_data (ev_rd_data)
	);

	pemr_ram #(
		.WIDTH (TAG_W),
		.DEPTH (RING_DEPTH)
	) u_pemr_tag_ram (
		.clk     (clk),
		.wr_en   (tag_we),
		.wr_addr (tag_wr_q),
		.wr_data (req_tag),
		.rd_en   (s1_load),
		.rd_addr (tag_rd_q),
		.rd_data (tag_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_rd_q   <= '0;
			ev_wr_q   <= '0;
			tag_rd_q  <= '0;
			tag_wr_q  <= '0;
			stalled_q <= 1'b0;
			resized_q <= 1'b0;
			last_ev_q <= '0;
			valid_s1  <= 1'b0;
			kind_s1   <= KIND_ERR;
		end else begin
			ev_rd_q   <= ev_rd_d;
			ev_wr_q   <= ev_wr_d;
			tag_rd_q  <= tag_rd_d;
			tag_wr_q  <= tag_wr_d;
			stalled_q <= stalled_d;
			resized_q <= resized_d;
			last_ev_q <= last_ev_d;
			if (s1_load) begin
				valid_s1 <= valid_d;
				kind_s1  <= kind_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			tag_s1     <= req_tag;
			ev_s1      <= queued_ev;
			resized_s1 <= resized_out_d;
		end
	end

	// pick each field from the first stage or from the ring read
	always_comb begin
		res_err = 1'b0;
		res_tag = '0;
		res_ev  = '0;
		case (kind_s1)
			KIND_ERR: begin
				res_err = 1'b1;
			end
			KIND_EV_MEM: begin
				res_tag = tag_s1;
				res_ev  = ev_rd_data;
			end
			KIND_TAG_MEM: begin
				res_tag = tag_rd_data;
				res_ev  = ev_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			is_error_q    <= res_err;
			reply_tag_q   <= res_tag;
			res_ev_q      <= res_ev;
			was_resized_q <= res_err ? 1'b0 : resized_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign is_error     = is_error_q;
	assign reply_tag    = reply_tag_q;
	assign out_x        = res_ev_q.x;
	assign out_y        = res_ev_q.y;
	assign out_buttons  = res_ev_q.buttons;
	assign out_stamp    = res_ev_q.stamp;
	assign was_resized  = was_resized_q;

endmodule

@@ sv/pemr_checker.sv @@
`timescale 1ns / 1ps

module pemr_checker
	import pemr_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      item_valid,
	input logic                      item_stall,
	input logic [1:0]                action,
	input logic [TAG_W-1:0]          req_tag,
	input logic signed [COORD_W-1:0] pos_x,
	input logic signed [COORD_W-1:0] pos_y,
	input logic [BTN_W-1:0]          button_bits,
	input logic [STAMP_W-1:0]        stamp_ms,
	input logic [BTN_W-1:0]          modifier_buttons,
	input logic                      result_valid,
	input logic                      result_stall,
	input logic                      is_error,
	input logic [TAG_W-1:0]          reply_tag,
	input logic signed [COORD_W-1:0] out_x,
	input logic signed [COORD_W-1:0] out_y,
	input logic [BTN_W-1:0]          out_buttons,
	input logic [STAMP_W-1:0]        out_stamp,
	input logic                      was_resized
);

	// hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(is_error)
		&& $stable(reply_tag) && $stable(out_x) && $stable(out_y)
		&& $stable(out_buttons) && $stable(out_stamp) && $stable(was_resized))
		else $error("stalled result changed");

	// an error result carries nothing else
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_error |-> reply_tag == '0 && out_x == '0 && out_y == '0
		&& out_buttons == '0 && out_stamp == '0 && !was_resized)
		else $error("error result with non-zero fields");

	// input side stalls only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without back-pressure");

	// a fresh result traces back to an accepted item, through the first stage and the result register
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && !item_stall, 2))
		else $error("result without an accepted item");

endmodule

bind pointer_event_read_matcher_unit pemr_checker u_pemr_checker (.*);
